### hw/rtl/pld_pkg.sv
// Shared types and constants for the point-to-line distance pipeline.
// No dependencies; used by the divider cells, root cells and the top level.
package pld_pkg;

  localparam int CoordW  = 16;          // input coordinate width
  localparam int FootW   = 20;          // output foot width
  localparam int DistW   = 19;          // output distance width
  localparam int DenW    = 34;          // squared line length
  localparam int NumW    = 51;          // dividend magnitude plus half divisor
  localparam int QuotW   = 18;          // quotient magnitude bits
  localparam int SqW     = 42;          // sum of squared offsets
  localparam int RootW   = 43;          // root accumulator during iteration
  localparam int DivSteps  = QuotW;
  localparam int SqrtSteps = SqW / 2;

  localparam logic signed [FootW-1:0] FootMax = 20'sd524287;
  localparam logic signed [FootW-1:0] FootMin = -20'sd524288;
  localparam logic [DistW-1:0]        DistMax = 19'd524287;

  // Inputs that ride along the divider chain
  typedef struct packed {
    logic                     degen;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
  } pld_pass_t;

  // Word handed from one divider cell to the next
  typedef struct packed {
    pld_pass_t         pass;
    logic [DenW-1:0]   den;
    logic [NumW-1:0]   rem_x;
    logic [NumW-1:0]   rem_y;
    logic              neg_x;
    logic              neg_y;
    logic [QuotW-1:0]  q_x;
    logic [QuotW-1:0]  q_y;
  } pld_div_t;

  // Word handed from one root cell to the next
  typedef struct packed {
    logic                    degen;
    logic signed [FootW-1:0] fx;
    logic signed [FootW-1:0] fy;
    logic [SqW-1:0]          rem;
    logic [RootW-1:0]        root;
  } pld_sqrt_t;

endpackage

### hw/rtl/pld_div_cell.sv
// One restoring-division cell: decides one quotient bit for both foot axes.
// Depends on pld_pkg.
module pld_div_cell
  import pld_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  pld_div_t in_word,
  output logic     out_valid,
  output pld_div_t out_word
);

  logic [NumW-1:0] shd;
  pld_div_t        word_next;

  // Compare each remainder against the shifted divisor
  always_comb begin
    shd       = NumW'(in_word.den) << STEP;
    word_next = in_word;
    if (in_word.rem_x >= shd) begin
      word_next.rem_x   = in_word.rem_x - shd;
      word_next.q_x[STEP] = 1'b1;
    end
    if (in_word.rem_y >= shd) begin
      word_next.rem_y   = in_word.rem_y - shd;
      word_next.q_y[STEP] = 1'b1;
    end
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Advance word
  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

### hw/rtl/pld_sqrt_cell.sv
// One digit-by-digit square root cell: settles one root bit.
// Depends on pld_pkg.
module pld_sqrt_cell
  import pld_pkg::*;
#(
  parameter int K = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  pld_sqrt_t in_word,
  output logic      out_valid,
  output pld_sqrt_t out_word
);

  localparam logic [RootW-1:0] Bit = RootW'(1) << (2 * K);

  logic [RootW-1:0] trial;
  pld_sqrt_t        word_next;

  // Try root plus bit against the remainder
  always_comb begin
    trial     = in_word.root + Bit;
    word_next = in_word;
    if ({1'b0, in_word.rem} >= trial) begin
      word_next.rem  = in_word.rem - trial[SqW-1:0];
      word_next.root = (in_word.root >> 1) + Bit;
    end else begin
      word_next.root = in_word.root >> 1;
    end
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Advance word
  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

### hw/rtl/point_line_distance.sv
// Top level: perpendicular foot and distance from a point to a line.
// Depends on pld_pkg, pld_div_cell and pld_sqrt_cell.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+--------------------
//   command  | line_ax/ay, line_bx/by, query_px/py     | start & !busy
//   result   | foot_x, foot_y, distance, degenerate    | done, one cycle
//
// One word is taken every cycle; busy stays low. A result passes through
// 6 front stages, 18 divider cells, 4 stages for the foot and squared
// offsets, 21 root cells and the output register.
// Reset clears all valid bits; results in flight are dropped.
// The receiver cannot stall, so no stage ever holds.
module point_line_distance
  import pld_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] line_ax,
  input  logic signed [CoordW-1:0] line_ay,
  input  logic signed [CoordW-1:0] line_bx,
  input  logic signed [CoordW-1:0] line_by,
  input  logic signed [CoordW-1:0] query_px,
  input  logic signed [CoordW-1:0] query_py,
  output logic                     done,
  output logic signed [FootW-1:0]  foot_x,
  output logic signed [FootW-1:0]  foot_y,
  output logic [DistW-1:0]         distance,
  output logic                     degenerate
);

  localparam int Latency = 6 + DivSteps + 4 + SqrtSteps + 1;

  // ---------------- front stages ----------------
  logic                      s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  pld_pass_t                 s1_p, s2_p, s3_p, s4_p, s5_p;
  logic signed [16:0]        s1_dx, s1_dy, s1_wx, s1_wy;
  logic signed [16:0]        s2_dx, s2_dy, s3_dx, s3_dy;
  logic signed [33:0]        s2_wdx, s2_wdy;
  logic [33:0]               s2_ddx, s2_ddy;
  logic signed [34:0]        s3_dot;
  logic [DenW-1:0]           s3_len2, s4_len2, s5_len2;
  logic signed [34:0]        s4_px_lo, s4_px_hi, s4_py_lo, s4_py_hi;
  logic signed [51:0]        s5_num_x, s5_num_y;
  pld_div_t                  s6_w;
  logic                      in_accept;
  logic signed [16:0]        dx_in, dy_in;
  logic signed [17:0]        dot_lo, dot_hi;

  assign busy      = 1'b0;
  assign in_accept = start & ~busy;
  assign dx_in     = 17'(line_bx) - 17'(line_ax);
  assign dy_in     = 17'(line_by) - 17'(line_ay);
  assign dot_lo    = $signed({1'b0, s3_dot[16:0]});
  assign dot_hi    = s3_dot[34:17];

  // Advance front valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else begin
      s1_v <= in_accept;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
  end

  // Differences, products, dot and length, split products, dividend
  always_ff @(posedge clk) begin
    s1_p.degen <= (dx_in == '0) && (dy_in == '0);
    s1_p.ax    <= line_ax;
    s1_p.ay    <= line_ay;
    s1_p.px    <= query_px;
    s1_p.py    <= query_py;
    s1_dx      <= dx_in;
    s1_dy      <= dy_in;
    s1_wx      <= 17'(query_px) - 17'(line_ax);
    s1_wy      <= 17'(query_py) - 17'(line_ay);

    s2_p   <= s1_p;
    s2_dx  <= s1_dx;
    s2_dy  <= s1_dy;
    s2_wdx <= s1_wx * s1_dx;
    s2_wdy <= s1_wy * s1_dy;
    s2_ddx <= 34'(s1_dx * s1_dx);
    s2_ddy <= 34'(s1_dy * s1_dy);

    s3_p    <= s2_p;
    s3_dx   <= s2_dx;
    s3_dy   <= s2_dy;
    s3_dot  <= 35'(s2_wdx) + 35'(s2_wdy);
    s3_len2 <= s2_ddx + s2_ddy;

    s4_p     <= s3_p;
    s4_len2  <= s3_len2;
    s4_px_lo <= 35'(s3_dx * dot_lo);
    s4_px_hi <= 35'(s3_dx * dot_hi);
    s4_py_lo <= 35'(s3_dy * dot_lo);
    s4_py_hi <= 35'(s3_dy * dot_hi);

    s5_p     <= s4_p;
    s5_len2  <= s4_len2;
    s5_num_x <= (52'(s4_px_hi) <<< 17) + 52'(s4_px_lo);
    s5_num_y <= (52'(s4_py_hi) <<< 17) + 52'(s4_py_lo);

    s6_w.pass  <= s5_p;
    s6_w.den   <= s5_len2;
    s6_w.neg_x <= s5_num_x[51];
    s6_w.neg_y <= s5_num_y[51];
    s6_w.rem_x <= NumW'(s5_num_x[51] ? -s5_num_x : s5_num_x) + NumW'(s5_len2 >> 1);
    s6_w.rem_y <= NumW'(s5_num_y[51] ? -s5_num_y : s5_num_y) + NumW'(s5_len2 >> 1);
    s6_w.q_x   <= '0;
    s6_w.q_y   <= '0;
  end

  // ---------------- divider chain ----------------
  logic     dv_v [DivSteps+1];
  pld_div_t dv_w [DivSteps+1];

  assign dv_v[0] = s6_v;
  assign dv_w[0] = s6_w;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    pld_div_cell #(.STEP(DivSteps - 1 - i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv_v[i]),
      .in_word  (dv_w[i]),
      .out_valid(dv_v[i+1]),
      .out_word (dv_w[i+1])
    );
  end

  // ---------------- foot, offsets, squares ----------------
  pld_div_t                  dq;
  logic signed [QuotW:0]     qs_x, qs_y;
  logic signed [FootW:0]     fx_full, fy_full;
  logic signed [FootW-1:0]   fx_sat, fy_sat;
  logic                      s7_v, s8_v, s9_v, s10_v;
  logic                      s7_d, s8_d, s9_d;
  logic signed [FootW-1:0]   s7_fx, s7_fy, s8_fx, s8_fy, s9_fx, s9_fy;
  logic signed [CoordW-1:0]  s7_px, s7_py;
  logic signed [FootW:0]     s8_ex, s8_ey;
  logic [SqW-1:0]            s9_sx, s9_sy;
  pld_sqrt_t                 s10_w;

  assign dq      = dv_w[DivSteps];
  assign qs_x    = dq.neg_x ? -$signed({1'b0, dq.q_x}) : $signed({1'b0, dq.q_x});
  assign qs_y    = dq.neg_y ? -$signed({1'b0, dq.q_y}) : $signed({1'b0, dq.q_y});
  assign fx_full = 21'(dq.pass.ax) + 21'(qs_x);
  assign fy_full = 21'(dq.pass.ay) + 21'(qs_y);

  // Clamp the foot to the output range
  always_comb begin
    if (fx_full > 21'(FootMax)) begin
      fx_sat = FootMax;
    end else if (fx_full < 21'(FootMin)) begin
      fx_sat = FootMin;
    end else begin
      fx_sat = fx_full[FootW-1:0];
    end
    if (fy_full > 21'(FootMax)) begin
      fy_sat = FootMax;
    end else if (fy_full < 21'(FootMin)) begin
      fy_sat = FootMin;
    end else begin
      fy_sat = fy_full[FootW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v  <= 1'b0;
      s8_v  <= 1'b0;
      s9_v  <= 1'b0;
      s10_v <= 1'b0;
    end else begin
      s7_v  <= dv_v[DivSteps];
      s8_v  <= s7_v;
      s9_v  <= s8_v;
      s10_v <= s9_v;
    end
  end

  always_ff @(posedge clk) begin
    s7_d  <= dq.pass.degen;
    s7_fx <= dq.pass.degen ? FootW'(dq.pass.ax) : fx_sat;
    s7_fy <= dq.pass.degen ? FootW'(dq.pass.ay) : fy_sat;
    s7_px <= dq.pass.px;
    s7_py <= dq.pass.py;

    s8_d  <= s7_d;
    s8_fx <= s7_fx;
    s8_fy <= s7_fy;
    s8_ex <= 21'(s7_px) - 21'(s7_fx);
    s8_ey <= 21'(s7_py) - 21'(s7_fy);

    s9_d  <= s8_d;
    s9_fx <= s8_fx;
    s9_fy <= s8_fy;
    s9_sx <= SqW'(s8_ex * s8_ex);
    s9_sy <= SqW'(s8_ey * s8_ey);

    s10_w.degen <= s9_d;
    s10_w.fx    <= s9_fx;
    s10_w.fy    <= s9_fy;
    s10_w.rem   <= s9_sx + s9_sy;
    s10_w.root  <= '0;
  end

  // ---------------- root chain ----------------
  logic      sr_v [SqrtSteps+1];
  pld_sqrt_t sr_w [SqrtSteps+1];

  assign sr_v[0] = s10_v;
  assign sr_w[0] = s10_w;

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    pld_sqrt_cell #(.K(SqrtSteps - 1 - j)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sr_v[j]),
      .in_word  (sr_w[j]),
      .out_valid(sr_v[j+1]),
      .out_word (sr_w[j+1])
    );
  end

  // ---------------- round, clamp, output register ----------------
  pld_sqrt_t        sf;
  logic [RootW-1:0] root_rnd;

  assign sf       = sr_w[SqrtSteps];
  assign root_rnd = ({1'b0, sf.rem} > sf.root) ? sf.root + RootW'(1) : sf.root;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sr_v[SqrtSteps];
    end
  end

  always_ff @(posedge clk) begin
    foot_x     <= sf.fx;
    foot_y     <= sf.fy;
    degenerate <= sf.degen;
    distance   <= (root_rnd > RootW'(DistMax)) ? DistMax : root_rnd[DistW-1:0];
  end

`ifndef SYNTHESIS
  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    in_accept |-> ##Latency done)
    else $error("command word produced no result");

  a_result_has_cmd : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_accept, Latency))
    else $error("result without a command");

  a_degen_foot : assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |->
      (foot_x == FootW'($past(line_ax, Latency))) &&
      (foot_y == FootW'($past(line_ay, Latency))))
    else $error("degenerate foot is not the first line point");
`endif

endmodule

### bench/point_line_distance_checker.sv
// Checker for the point-to-line distance block: predicts foot and distance
// for each accepted command word and compares every result word. Uses pld_pkg.
module point_line_distance_checker
  import pld_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic signed [CoordW-1:0] line_ax,
  input  logic signed [CoordW-1:0] line_ay,
  input  logic signed [CoordW-1:0] line_bx,
  input  logic signed [CoordW-1:0] line_by,
  input  logic signed [CoordW-1:0] query_px,
  input  logic signed [CoordW-1:0] query_py,
  input  logic                     done,
  input  logic signed [FootW-1:0]  foot_x,
  input  logic signed [FootW-1:0]  foot_y,
  input  logic [DistW-1:0]         distance,
  input  logic                     degenerate,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [FootW-1:0] fx;
    logic signed [FootW-1:0] fy;
    logic [DistW-1:0]        span;
    logic                    degen;
  } foot_word_t;

  foot_word_t foot_queue[$];

  // Round to nearest, ties away from zero; den > 0
  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp_foot(longint v);
    if (v > FootMax) return FootMax;
    if (v < FootMin) return FootMin;
    return v;
  endfunction

  function automatic longint round_root(longint s);
    longint r;
    r = longint'($floor($sqrt(real'(s))));
    while (r * r > s) r--;
    while ((r + 1) * (r + 1) <= s) r++;
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic foot_word_t project_point(longint ax, longint ay, longint bx,
                                               longint by, longint px, longint py);
    foot_word_t w;
    longint dx, dy, dot, len2, fx, fy, ex, ey, d;
    dx = bx - ax;
    dy = by - ay;
    w.degen = (dx == 0 && dy == 0);
    if (w.degen) begin
      fx = ax;
      fy = ay;
    end else begin
      dot = (px - ax) * dx + (py - ay) * dy;
      len2 = dx * dx + dy * dy;
      fx = clamp_foot(ax + round_div(dx * dot, len2));
      fy = clamp_foot(ay + round_div(dy * dot, len2));
    end
    ex = px - fx;
    ey = py - fy;
    d = round_root(ex * ex + ey * ey);
    if (d > DistMax) d = DistMax;
    w.fx = FootW'(fx);
    w.fy = FootW'(fy);
    w.span = DistW'(d);
    return w;
  endfunction

  assign pending = foot_queue.size();

  // Predict on accepted command words, compare on strobed result words
  always @(posedge clk) begin
    foot_word_t exp_w;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (done) begin
        if (foot_queue.size() == 0) begin
          $display("%0t: result word with none expected: %h %h %h %b", $time,
                   foot_x, foot_y, distance, degenerate);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = foot_queue.pop_front();
          if (exp_w.fx !== foot_x || exp_w.fy !== foot_y ||
              exp_w.span !== distance || exp_w.degen !== degenerate) begin
            $display("%0t: mismatch expected fx=%0d fy=%0d d=%0d dg=%b", $time,
                     exp_w.fx, exp_w.fy, exp_w.span, exp_w.degen);
            $display("%0t:          actual   fx=%0d fy=%0d d=%0d dg=%b", $time,
                     foot_x, foot_y, distance, degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        foot_queue.push_back(project_point(line_ax, line_ay, line_bx, line_by,
                                           query_px, query_py));
    end
  end
endmodule

### bench/point_line_distance_tb.sv
// Testbench top for point_line_distance: clock, reset, directed and random
// command words, verdict. Uses pld_pkg and point_line_distance_checker.
module point_line_distance_tb;
  import pld_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 50;
  localparam int CycleLimit = 200000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done, degenerate;
  logic signed [CoordW-1:0] line_ax = 0, line_ay = 0, line_bx = 0, line_by = 0;
  logic signed [CoordW-1:0] query_px = 0, query_py = 0;
  logic signed [FootW-1:0] foot_x, foot_y;
  logic [DistW-1:0] distance;
  int fail_count, pending, cycles = 0;
  int idle_pct = 0;

  always #5 clk = ~clk;

  point_line_distance dut (.*);
  point_line_distance_checker chk (.*);

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Send one word, idling first at random
  task automatic send_word(int ax, int ay, int bx, int by, int px, int py);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    line_ax <= CoordW'(ax); line_ay <= CoordW'(ay);
    line_bx <= CoordW'(bx); line_by <= CoordW'(by);
    query_px <= CoordW'(px); query_py <= CoordW'(py);
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Pick a coordinate: mostly full range, some extremes or small values
  function automatic int pick_coord();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return $signed(16'($urandom_range(511))) - 256;
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  task automatic send_random();
    int ax, ay, bx, by;
    ax = pick_coord();
    ay = pick_coord();
    case ($urandom_range(9))
      0: begin bx = ax; by = ay; end           // coincident points
      1: begin bx = ax; by = pick_coord(); end // vertical line
      2: begin bx = pick_coord(); by = ay; end // horizontal line
      default: begin bx = pick_coord(); by = pick_coord(); end
    endcase
    send_word(ax, ay, bx, by, pick_coord(), pick_coord());
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 0;
    // Directed: extremes, vertical, horizontal, coincident, ties
    send_word(0, 0, 0, 0, 0, 0);
    send_word(-32768, -32768, -32768, -32768, 32767, 32767);
    send_word(32767, 32767, 32767, 32767, -32768, -32768);
    send_word(100, -200, 100, 500, -32768, 32767);
    send_word(-300, 77, 900, 77, 32767, -32768);
    send_word(-32768, 0, -32768, 1, 32767, 0);
    send_word(0, -32768, 1, -32768, 0, 32767);
    send_word(-32768, -32768, 32767, 32767, -32768, 32767);
    send_word(-32768, 32767, 32767, -32768, 32767, 32767);
    send_word(-32768, -32768, 32767, -32767, 32767, 32767);
    send_word(0, 0, 2, 0, 1, 5);
    send_word(0, 0, 2, 2, 1, 0);
    send_word(0, 0, 3, 1, 1, 1);
    send_word(0, 0, 1, 1, -1, 2);
    send_word(5, 5, 6, 6, 5, 5);
    send_word(-1, -1, 1, 1, 32767, -32768);
    send_word(32767, -32768, -32768, 32767, 0, 0);
    send_word(-21846, 10922, 21845, -5461, -1, -1);
    // Hold off until the pipe drains
    start <= 0;
    while (pending != 0) @(negedge clk);
    // Random phases: sender idles 35%, then 86%, then never
    idle_pct = 35;
    repeat (550) send_random();
    idle_pct = 86;
    repeat (550) send_random();
    start <= 0;
    while (pending != 0) @(negedge clk);
    idle_pct = 0;
    repeat (550) send_random();
    start <= 0;
    while (pending != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
